### hw/rtl/cpts_pkg.sv
// Shared types, constants and helpers of the counter priority task scheduler.
`timescale 1ns / 1ps

package cpts_pkg;

  // Table size and field widths
  localparam int NUM_TASKS    = 64;
  localparam int SLOT_W       = $clog2(NUM_TASKS);
  localparam int SCAN_W       = $clog2(NUM_TASKS + 1);
  localparam int TASK_INDEX_W = 6;
  localparam int PRIO_W       = 8;
  localparam int CNT_W        = 16;
  localparam int DEPTH_W      = 8;
  localparam int CMD_W        = 3;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;

  localparam logic [PRIO_W-1:0] INIT_PRIO_RST = 8'd1;
  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] CNT_NONE = '1;  // -1: no candidate yet

  // Command codes on in_tuser
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SETRUN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HOLD    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CUR_WRITE,
    OP_LOAD,
    OP_SETRUN,
    OP_HOLD,
    OP_RELEASE,
    OP_REFILL
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [TASK_INDEX_W-1:0]   index;
    logic [PRIO_W-1:0]         prio;
    logic                      run;
    logic signed [CNT_W-1:0]   value;
    logic [SLOT_W-1:0]         cur;
  } cell_cmd_t;

  // Counter and preempt depth of one slot, seen by the controller
  typedef struct packed {
    logic signed [CNT_W-1:0] counter;
    logic [DEPTH_W-1:0]      depth;
  } cell_stat_t;

  // Best candidate handed from cell to cell
  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic [SLOT_W-1:0]       idx;
  } best_t;

  // Task index of a command addresses this slot
  function automatic logic slot_hit(input logic [TASK_INDEX_W-1:0] ix,
                                    input logic [SLOT_W-1:0] s);
    return (32'(ix) == 32'(s));
  endfunction

  // Decrement, holding at the most negative value
  function automatic logic signed [CNT_W-1:0] sat_dec(input logic signed [CNT_W-1:0] c);
    return (c == CNT_MIN) ? c : c - CNT_W'(1);
  endfunction

  // floor(c/2) + priority, holding at the most positive value
  function automatic logic signed [CNT_W-1:0] refill(input logic signed [CNT_W-1:0] c,
                                                     input logic [PRIO_W-1:0] p);
    logic signed [CNT_W:0] s;
    s = ($signed({c[CNT_W-1], c}) >>> 1) + $signed({{(CNT_W+1-PRIO_W){1'b0}}, p});
    return (s[CNT_W] != s[CNT_W-1]) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

### hw/rtl/cpts_cell.sv
// One task slot: its state, its command decode and one step of the pick chain.
`timescale 1ns / 1ps

module cpts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cpts_pkg::SLOT_W-1:0]   my_idx,
  input  cpts_pkg::cell_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [cpts_pkg::PRIO_W-1:0]   cfg_wdata,
  input  cpts_pkg::best_t               best_in,
  output cpts_pkg::best_t               best_out,
  output cpts_pkg::cell_stat_t          stat
);
  import cpts_pkg::*;

  logic                    valid_r, valid_nxt;
  logic                    run_r, run_nxt;
  logic [PRIO_W-1:0]       prio_r, prio_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEPTH_W-1:0]      depth_r, depth_nxt;
  best_t                   best_r, best_nxt;
  logic                    is_zero, is_cur, is_tgt, cand;

  assign is_zero = (my_idx == '0);
  assign is_cur  = (cmd.cur == my_idx);
  assign is_tgt  = slot_hit(cmd.index, my_idx);

  // Slot update for the broadcast operation
  always_comb begin
    valid_nxt = valid_r;
    run_nxt   = run_r;
    prio_nxt  = prio_r;
    cnt_nxt   = cnt_r;
    depth_nxt = depth_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_CUR_WRITE: begin
        if (is_cur) cnt_nxt = cmd.value;
      end
      OP_LOAD: begin
        if (is_tgt) begin
          valid_nxt = 1'b1;
          run_nxt   = cmd.run;
          prio_nxt  = cmd.prio;
          cnt_nxt   = $signed({{(CNT_W-PRIO_W){1'b0}}, cmd.prio});
          depth_nxt = '0;
        end
      end
      OP_SETRUN: begin
        if (is_tgt) run_nxt = cmd.run;
      end
      OP_HOLD: begin
        if (is_cur && depth_r != '1) depth_nxt = depth_r + DEPTH_W'(1);
      end
      OP_RELEASE: begin
        if (is_cur && depth_r != '0) depth_nxt = depth_r - DEPTH_W'(1);
      end
      OP_REFILL: begin
        if (valid_r) cnt_nxt = refill(cnt_r, prio_r);
      end
      default: ;
    endcase
    // init_priority lands in slot zero
    if (cfg_we && is_zero) prio_nxt = cfg_wdata;
  end

  // Pick step: take over only on a strictly larger counter, so lower index wins ties
  assign cand     = valid_r && run_r && (cnt_r > best_in.cnt);
  assign best_nxt = cand ? best_t'{cnt: cnt_r, idx: my_idx} : best_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= is_zero;
      run_r   <= is_zero;
      prio_r  <= is_zero ? INIT_PRIO_RST : '0;
      cnt_r   <= '0;
      depth_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      run_r   <= run_nxt;
      prio_r  <= prio_nxt;
      cnt_r   <= cnt_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Chain register, flushed by every scan pass
  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best_out      = best_r;
  assign stat.counter  = cnt_r;
  assign stat.depth    = depth_r;

endmodule

### hw/rtl/cpts_ctrl.sv
// Sequencer: command decode, scan timing, refill decision and result register.
`timescale 1ns / 1ps

module cpts_ctrl (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [cpts_pkg::IN_DATA_W-1:0]             in_tdata,
  input  logic [cpts_pkg::CMD_W-1:0]                 in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [cpts_pkg::OUT_DATA_W-1:0]            out_tdata,
  input  cpts_pkg::cell_stat_t [cpts_pkg::NUM_TASKS-1:0] stat,
  input  cpts_pkg::best_t                            best_last,
  output cpts_pkg::cell_cmd_t                        cmd
);
  import cpts_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t                  state_r;
  logic [SLOT_W-1:0]       cur_r;
  logic [SCAN_W-1:0]       scan_r;
  logic                    refilled_r;
  logic                    switched_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic                    accept;
  logic [CMD_W-1:0]        in_cmd;
  cell_stat_t              cur_stat;
  logic signed [CNT_W-1:0] dec;
  logic                    keep, resched, scan_done, do_refill, fire;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_cmd    = in_tuser;
  assign cur_stat  = stat[cur_r];

  // Tick: decrement and decide whether the slice is used up
  assign dec     = sat_dec(cur_stat.counter);
  assign keep    = (!dec[CNT_W-1] && dec != '0) || (cur_stat.depth != '0);
  assign resched = (in_cmd == CMD_TICK && !keep) || (in_cmd == CMD_YIELD);

  assign scan_done = (scan_r == SCAN_W'(NUM_TASKS));
  assign do_refill = (state_r == ST_SCAN) && scan_done && !refilled_r &&
                     (best_last.cnt == '0);

  // Result goes out once the register is free or being taken
  assign fire = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  // Operation broadcast to the cells
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.index = in_tdata[5:0];
    cmd.prio  = in_tdata[13:6];
    cmd.run   = in_tdata[14];
    cmd.value = keep ? dec : '0;
    cmd.cur   = cur_r;
    if (accept) begin
      unique case (in_cmd)
        CMD_TICK:    cmd.op = OP_CUR_WRITE;
        CMD_YIELD: begin
          cmd.op    = OP_CUR_WRITE;
          cmd.value = '0;
        end
        CMD_LOAD:    cmd.op = OP_LOAD;
        CMD_SETRUN:  cmd.op = OP_SETRUN;
        CMD_HOLD:    cmd.op = OP_HOLD;
        CMD_RELEASE: cmd.op = OP_RELEASE;
        default:     cmd.op = OP_NONE;
      endcase
    end else if (do_refill) begin
      cmd.op = OP_REFILL;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      scan_r      <= '0;
      refilled_r  <= 1'b0;
      switched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            scan_r     <= '0;
            refilled_r <= 1'b0;
            switched_r <= 1'b0;
            state_r    <= resched ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            scan_r <= scan_r + SCAN_W'(1);
          end else if (do_refill) begin
            refilled_r <= 1'b1;
            scan_r     <= '0;
          end else begin
            cur_r      <= best_last.idx;
            switched_r <= (best_last.idx != cur_r);
            state_r    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            out_data_r  <= {1'b0, cur_stat.counter, switched_r, TASK_INDEX_W'(cur_r)};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/counter_priority_task_scheduler.sv
// Top level: row of task-slot cells and the sequencer that drives them.
//
//  channel | ports                      | contents (lowest bit up)
//  --------+----------------------------+----------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | tdata: task_index[5:0], task_priority[13:6],
//          |                            |        runnable[14], zero[15]; tuser: cmd
//  out     | out_tvalid/tready/tdata    | current_task[5:0], switched[6],
//          |                            | current_counter[22:7], zero[23]
//  cfg     | cfg_we, cfg_wdata          | init_priority[7:0], written into slot zero
//
// A command without reschedule goes straight to the finish state. A reschedule runs
// a pick pass down the cell chain, plus one more pass after a refill, its length set
// by the chain length. Synchronous reset restores every slot; no clearing pass.
// A new transaction is taken only when the sequencer is idle; a result held by
// out_tready low stalls the next one only in its finish state.
`timescale 1ns / 1ps

module counter_priority_task_scheduler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // task_index[5:0], task_priority[13:6], runnable[14], zero[15]
  input  logic [cpts_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd[2:0]
  input  logic [cpts_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_task[5:0], switched[6], current_counter[22:7], zero[23]
  output logic [cpts_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [cpts_pkg::PRIO_W-1:0]         cfg_wdata
);
  import cpts_pkg::*;

  cell_cmd_t                    cmd;
  cell_stat_t [NUM_TASKS-1:0]   stat;
  best_t                        chain [0:NUM_TASKS];

  // Chain head: nothing found yet, default slot zero
  assign chain[0] = '{cnt: CNT_NONE, idx: '0};

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    cpts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .my_idx    (SLOT_W'(i)),
      .cmd       (cmd),
      .cfg_we    (cfg_we),
      .cfg_wdata (cfg_wdata),
      .best_in   (chain[i]),
      .best_out  (chain[i+1]),
      .stat      (stat[i])
    );
  end

  cpts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (stat),
    .best_last  (chain[NUM_TASKS]),
    .cmd        (cmd)
  );

endmodule

### hw/rtl/cpts_checker.sv
// Port-level checks on the scheduler, bound to the top level.
`timescale 1ns / 1ps

module cpts_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [cpts_pkg::CMD_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cpts_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import cpts_pkg::*;

  logic [CMD_W-1:0] head_cmd_r, tail_cmd_r;
  logic [1:0]       pend_r;
  logic             in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Commands of transactions whose results are still owed, oldest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_cmd_r <= CMD_LOAD;
      tail_cmd_r <= CMD_LOAD;
      pend_r     <= '0;
    end else begin
      if (out_acc) begin
        head_cmd_r <= (in_acc && pend_r == 2'd1) ? in_tuser : tail_cmd_r;
      end else if (in_acc && pend_r == 2'd0) begin
        head_cmd_r <= in_tuser;
      end
      if (in_acc && (pend_r == 2'd2 || (pend_r == 2'd1 && !out_acc))) begin
        tail_cmd_r <= in_tuser;
      end
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One transaction in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  // Only tick or yield may switch tasks
  a_switch_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> (head_cmd_r == CMD_TICK) || (head_cmd_r == CMD_YIELD))
    else $error("task switch without tick or yield");

  // Pad bit stays clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[OUT_DATA_W-1])
    else $error("pad bit set in result");

endmodule

bind counter_priority_task_scheduler cpts_checker u_chk (.*);
